### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bopd_pkg.sv
// ---------------------------------------------------------------------------
// bopd_pkg
// Types, constants and helpers for the byte-offset pixel decoder.
// ---------------------------------------------------------------------------
package bopd_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int SIZE_W   = 13;
    localparam int VALUE_W  = 31;
    localparam int SUM_W    = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0]  START_MARKER = 8'hD5;
    localparam logic [7:0]  ESC_BYTE     = 8'h80;
    localparam logic [15:0] ESC_WORD     = 16'h8000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] FAST_SIZE_RST = 13'd2463;
    localparam logic [SIZE_W-1:0] SLOW_SIZE_RST = 13'd2527;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_NEXT,
        PH_W0,
        PH_W1,
        PH_D0,
        PH_D1,
        PH_D2,
        PH_D3
    } t_phase;

    typedef struct packed {
        logic [SUM_W-1:0] delta;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             last;
    } t_delta_item;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

### rtl/bopd_front.sv
// ---------------------------------------------------------------------------
// bopd_front
// Byte parser: marker search, escape handling, delta assembly and pixel
// position tracking. Emits one delta transaction per completed pixel.
// ---------------------------------------------------------------------------
module bopd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_byte,
    input  logic [bopd_pkg::SIZE_W-1:0]         i_fast_size,
    input  logic [bopd_pkg::SIZE_W-1:0]         i_slow_size,
    output logic                                o_push,
    output bopd_pkg::t_delta_item               o_item
);

    bopd_pkg::t_phase                 r_phase, n_phase;
    logic [23:0]                      r_partial, n_partial;
    logic [bopd_pkg::DIM_W-1:0]       r_col, n_col;
    logic [bopd_pkg::DIM_W-1:0]       r_row, n_row;

    logic                             emit;
    logic [bopd_pkg::SUM_W-1:0]       delta;
    logic [15:0]                      word;
    logic [bopd_pkg::SIZE_W-1:0]      col_inc, row_inc;
    logic                             row_end, frame_end;
    bopd_pkg::t_phase                 emit_phase;

    assign word      = {i_byte, r_partial[7:0]};
    assign col_inc   = {1'b0, r_col} + bopd_pkg::SIZE_W'(1);
    assign row_inc   = {1'b0, r_row} + bopd_pkg::SIZE_W'(1);
    assign row_end   = col_inc >= bopd_pkg::eff_size(i_fast_size);
    assign frame_end = row_end && (row_inc >= bopd_pkg::eff_size(i_slow_size));

    // after a pixel: back to data, or to marker search at frame end
    assign emit_phase = frame_end ? bopd_pkg::PH_SEEK : bopd_pkg::PH_NEXT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bopd_pkg::PH_SEEK;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partial <= n_partial;
    end

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        emit      = 1'b0;
        delta     = '0;
        if (i_accept) begin
            case (r_phase)
                bopd_pkg::PH_SEEK: begin
                    if (i_byte == bopd_pkg::START_MARKER) begin
                        n_phase = bopd_pkg::PH_NEXT;
                    end
                end
                bopd_pkg::PH_NEXT: begin
                    if (i_byte == bopd_pkg::ESC_BYTE) begin
                        n_phase = bopd_pkg::PH_W0;
                    end else begin
                        emit    = 1'b1;
                        delta   = {{24{i_byte[7]}}, i_byte};
                        n_phase = emit_phase;
                    end
                end
                bopd_pkg::PH_W0: begin
                    n_partial[7:0] = i_byte;
                    n_phase        = bopd_pkg::PH_W1;
                end
                bopd_pkg::PH_W1: begin
                    if (word == bopd_pkg::ESC_WORD) begin
                        n_phase = bopd_pkg::PH_D0;
                    end else begin
                        emit    = 1'b1;
                        delta   = {{16{word[15]}}, word};
                        n_phase = emit_phase;
                    end
                end
                bopd_pkg::PH_D0: begin
                    n_partial[7:0] = i_byte;
                    n_phase        = bopd_pkg::PH_D1;
                end
                bopd_pkg::PH_D1: begin
                    n_partial[15:8] = i_byte;
                    n_phase         = bopd_pkg::PH_D2;
                end
                bopd_pkg::PH_D2: begin
                    n_partial[23:16] = i_byte;
                    n_phase          = bopd_pkg::PH_D3;
                end
                bopd_pkg::PH_D3: begin
                    emit    = 1'b1;
                    delta   = {i_byte, r_partial};
                    n_phase = emit_phase;
                end
                default: begin
                    n_phase = bopd_pkg::PH_SEEK;
                end
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (emit) begin
            if (frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = row_inc[bopd_pkg::DIM_W-1:0];
            end else begin
                n_col = col_inc[bopd_pkg::DIM_W-1:0];
            end
        end
    end

    assign o_push      = emit;
    assign o_item.delta = delta;
    assign o_item.row   = r_row;
    assign o_item.col   = r_col;
    assign o_item.last  = frame_end;

endmodule

### rtl/bopd_fifo.sv
// ---------------------------------------------------------------------------
// bopd_fifo
// Short queue of delta transactions between parser and accumulator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bopd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bopd_pkg::t_delta_item i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output bopd_pkg::t_delta_item o_data
);

    bopd_pkg::t_delta_item              r_mem [bopd_pkg::QDEPTH];
    logic [bopd_pkg::QPTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [bopd_pkg::QCNT_W-1:0]        r_count, n_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == bopd_pkg::QCNT_W'(bopd_pkg::QDEPTH);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + bopd_pkg::QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - bopd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bopd_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bopd_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "queue overflow")
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid), "queue underflow")
    `ASSERT_ALWAYS(a_count_ptrs, i_clk, i_rst_n,
        (r_count[bopd_pkg::QPTR_W-1:0] == (r_wr_ptr - r_rd_ptr)), "count/pointer mismatch")

endmodule

### rtl/bopd_back.sv
// ---------------------------------------------------------------------------
// bopd_back
// Accumulator: running sum, clamp at zero, frame maximum, output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bopd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  bopd_pkg::t_delta_item                i_q_data,
    output logic                                 o_q_pop,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [bopd_pkg::VALUE_W-1:0]         o_pixel_value,
    output logic [bopd_pkg::DIM_W-1:0]           o_pixel_row,
    output logic [bopd_pkg::DIM_W-1:0]           o_pixel_col,
    output logic [bopd_pkg::VALUE_W-1:0]         o_running_max,
    output logic                                 o_last_pixel
);

    logic [bopd_pkg::SUM_W-1:0]   r_sum;
    logic [bopd_pkg::VALUE_W-1:0] r_max;
    logic                         r_out_valid;
    logic [bopd_pkg::VALUE_W-1:0] r_value, r_omax;
    logic [bopd_pkg::DIM_W-1:0]   r_row, r_col;
    logic                         r_last;

    logic                         load;
    logic [bopd_pkg::SUM_W-1:0]   n_sum;
    logic [bopd_pkg::VALUE_W-1:0] n_value, n_max;

    assign load    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = load;
    assign n_sum   = r_sum + i_q_data.delta;
    assign n_value = n_sum[bopd_pkg::SUM_W-1] ? '0 : n_sum[bopd_pkg::VALUE_W-1:0];
    assign n_max   = (n_value > r_max) ? n_value : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (i_q_data.last) begin
                    r_sum <= '0;
                    r_max <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_max <= n_max;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= n_value;
            r_omax  <= n_max;
            r_row   <= i_q_data.row;
            r_col   <= i_q_data.col;
            r_last  <= i_q_data.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_value;
    assign o_pixel_row   = r_row;
    assign o_pixel_col   = r_col;
    assign o_running_max = r_omax;
    assign o_last_pixel  = r_last;

    `ASSERT_NEXT(a_frame_clear, i_clk, i_rst_n, load && i_q_data.last,
        (r_sum == '0) && (r_max == '0), "sums not cleared after frame")
    `ASSERT_ALWAYS(a_max_bound, i_clk, i_rst_n,
        !r_out_valid || (r_omax >= r_value), "running max below pixel")

endmodule

### rtl/byte_offset_pixel_decoder.sv
// Byte-offset pixel decoder. Takes one file byte per cycle unless o_in_stall
// is high: header bytes are dropped until the 0xD5 start marker, then 1-, 3-
// or 7-byte delta codes are decoded into pixels, each passing from its final
// byte through the four-entry delta queue and then the output register. The
// byte parser and the 32-bit accumulator each handle one transaction per
// clock unless stalled; the queue between them lets output stalls back up
// without stalling input until four deltas are pending. Size registers are
// clamped to 1..4096 and should be written only while the block is idle.
// ---------------------------------------------------------------------------
// byte_offset_pixel_decoder
// Top level: configuration registers, parser, delta queue and accumulator.
// ---------------------------------------------------------------------------
module byte_offset_pixel_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bopd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bopd_pkg::SIZE_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_in_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bopd_pkg::VALUE_W-1:0]         o_pixel_value,
    output logic [bopd_pkg::DIM_W-1:0]           o_pixel_row,
    output logic [bopd_pkg::DIM_W-1:0]           o_pixel_col,
    output logic [bopd_pkg::VALUE_W-1:0]         o_running_max,
    output logic                                 o_last_pixel
);

    logic [bopd_pkg::SIZE_W-1:0] r_fast_size, r_slow_size;
    logic                        in_accept;
    logic                        push, pop, q_valid, q_full;
    bopd_pkg::t_delta_item       push_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_size <= bopd_pkg::FAST_SIZE_RST;
            r_slow_size <= bopd_pkg::SLOW_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bopd_pkg::CFG_FAST_SIZE: r_fast_size <= i_cfg_data;
                bopd_pkg::CFG_SLOW_SIZE: r_slow_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    bopd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_in_byte),
        .i_fast_size (r_fast_size),
        .i_slow_size (r_slow_size),
        .o_push      (push),
        .o_item      (push_item)
    );

    bopd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_item)
    );

    bopd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_item),
        .o_q_pop       (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_value (o_pixel_value),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_col   (o_pixel_col),
        .o_running_max (o_running_max),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
